[rtl/pnc_pkg.sv]
// Shared types and constants for the page node carver and tracker.
// Holds beat structs, action, status, mark and configuration index codes.
// No dependencies.
package pnc_pkg;

    localparam int ADDR_W       = 48;
    localparam int SIZE_W       = 23;
    localparam int BASE_W       = 36;
    localparam int STAT_W       = 4;
    localparam int CNT_OUT_W    = 10;
    localparam int USE_OUT_W    = 11;
    localparam int TOTAL_W      = 64;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 4096;
    localparam int SIZE_PAGES_W = SIZE_W - PAGE_SHIFT;
    localparam int MARK_W       = 3;
    localparam int CFG_IDX_W    = 1;

    localparam logic [1:0] ACT_CARVE   = 2'd0;
    localparam logic [1:0] ACT_ISSUE   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_DISCARD = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 4'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE    = 4'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE    = 4'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR    = 4'd3;
    localparam logic [STAT_W-1:0] ST_UNMAPPED    = 4'd4;
    localparam logic [STAT_W-1:0] ST_NOT_START   = 4'd5;
    localparam logic [STAT_W-1:0] ST_ISSUE_ERR   = 4'd6;
    localparam logic [STAT_W-1:0] ST_RELEASE_ERR = 4'd7;
    localparam logic [STAT_W-1:0] ST_DISCARD_ERR = 4'd8;
    localparam logic [STAT_W-1:0] ST_MODE        = 4'd9;

    localparam int MK_LIVE      = 0;
    localparam int MK_RELEASED  = 1;
    localparam int MK_DISCARDED = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [SIZE_W-1:0] node_size;
        logic [ADDR_W-1:0] node_address;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ADDR_W-1:0]    result_address;
        logic [CNT_OUT_W-1:0] nodes_carved;
        logic [USE_OUT_W-1:0] pages_in_use;
        logic [TOTAL_W-1:0]   reuses_seen;
        logic [TOTAL_W-1:0]   releases_seen;
        logic [TOTAL_W-1:0]   discards_seen;
    } t_out_beat;

endpackage

[rtl/pnc_page_map.sv]
// Page-to-slot map: one write port, one read port, registered read data.
// Entries past the fill count are treated as unmapped by the caller.
// Depends on nothing.
module pnc_page_map #(
    parameter int PAGES = 1024,
    parameter int PW    = 10,
    parameter int SW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [PW-1:0] i_waddr,
    input  logic [SW-1:0] i_wdata,
    input  logic [PW-1:0] i_raddr,
    output logic [SW-1:0] o_rdata
);

    logic [SW-1:0] r_mem [PAGES];
    logic [SW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pnc_node_table.sv]
// Node record table: start page and marks per record, registered read data.
// Uses pnc_pkg for the mark width.
module pnc_node_table #(
    parameter int RECS = 512,
    parameter int RW   = 9,
    parameter int PW   = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [RW-1:0]             i_waddr,
    input  logic [PW-1:0]             i_wstart,
    input  logic [pnc_pkg::MARK_W-1:0] i_wmarks,
    input  logic [RW-1:0]             i_raddr,
    output logic [PW-1:0]             o_rstart,
    output logic [pnc_pkg::MARK_W-1:0] o_rmarks
);
    import pnc_pkg::*;

    logic [PW+MARK_W-1:0] r_mem [RECS];
    logic [PW+MARK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wstart, i_wmarks};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rstart = r_rdata[PW+MARK_W-1:MARK_W];
    assign o_rmarks = r_rdata[MARK_W-1:0];

endmodule

[rtl/page_node_carver_tracker.sv]
// Page node carver and tracker top level: sequencer, counters, config, output stage.
// Uses pnc_pkg, pnc_page_map and pnc_node_table.
// Issue/release/discard step through accept, check, map read, record RMW, emit.
// Carve: accept, check, one map write per covered page through the map port, then emit.
// Check-stage errors go straight to emit. The result register frees the input side.
// Reset (synchronous, active low) clears counters, config and fill count; no clearing pass.
module page_node_carver_tracker #(
    parameter int REGION_PAGES   = 1024,
    parameter int MIN_NODE_PAGES = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pnc_pkg::t_in_beat              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pnc_pkg::t_out_beat             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pnc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pnc_pkg::BASE_W-1:0]     i_cfg_data
);
    import pnc_pkg::*;

    localparam int RECORD_COUNT = REGION_PAGES / MIN_NODE_PAGES;
    localparam int PW   = (REGION_PAGES > 1) ? $clog2(REGION_PAGES) : 1;
    localparam int UW   = $clog2(REGION_PAGES + 1);
    localparam int SW   = $clog2(RECORD_COUNT + 1);
    localparam int RW   = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
    localparam int CMPW = (UW > SIZE_PAGES_W) ? UW : SIZE_PAGES_W;
    localparam int HI_W = ADDR_W - PAGE_SHIFT;
    localparam logic [SIZE_W-1:0] MIN_BYTES = SIZE_W'(MIN_NODE_PAGES * PAGE_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MAP   = 3'd2;
    localparam logic [2:0] S_REC   = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]          r_state;
    t_in_beat            r_req;
    logic [BASE_W-1:0]   r_base;
    logic                r_mode;
    logic [SW-1:0]       r_carved;
    logic [UW-1:0]       r_used;
    logic [TOTAL_W-1:0]  r_reuse;
    logic [TOTAL_W-1:0]  r_release;
    logic [TOTAL_W-1:0]  r_discard;
    logic [PW-1:0]       r_page;
    logic                r_mapped;
    logic [RW-1:0]       r_rec;
    logic [UW-1:0]       r_fill_pg;
    logic [UW-1:0]       r_fill_end;
    logic [STAT_W-1:0]   r_res_status;
    logic [ADDR_W-1:0]   r_res_addr;
    t_out_beat           r_out;
    logic                r_out_valid;

    logic [ADDR_W-1:0]   base_bytes;
    logic [ADDR_W-1:0]   off_bytes;
    logic                bad_addr;
    logic [PW-1:0]       req_page;
    logic                mapped;
    logic [SIZE_PAGES_W-1:0] size_pages;
    logic                bad_size;
    logic                no_space;
    logic                carve_ok;
    logic [CMPW-1:0]     avail;
    logic [ADDR_W-1:0]   carve_addr;
    logic [UW-1:0]       fill_next;
    logic                fill_last;

    logic                map_we;
    logic [SW-1:0]       map_wdata;
    logic [SW-1:0]       map_slot;
    logic [SW-1:0]       slot_m1;
    logic [RW-1:0]       rec_raddr;

    logic                rec_we;
    logic [RW-1:0]       rec_waddr;
    logic [PW-1:0]       rec_wstart;
    logic [MARK_W-1:0]   rec_wmarks;
    logic [PW-1:0]       rec_start;
    logic [MARK_W-1:0]   rec_marks;

    logic [MARK_W-1:0]   new_marks;
    logic [STAT_W-1:0]   mark_status;
    logic                inc_reuse;
    logic                inc_release;
    logic                inc_discard;
    logic                out_free;

    assign base_bytes = {r_base, {PAGE_SHIFT{1'b0}}};
    assign off_bytes  = r_req.node_address - base_bytes;
    assign bad_addr   = (r_req.node_address < base_bytes)
                     || (off_bytes[ADDR_W-1:PAGE_SHIFT] >= HI_W'(REGION_PAGES))
                     || (|r_req.node_address[PAGE_SHIFT-1:0]);
    assign req_page   = off_bytes[PAGE_SHIFT +: PW];
    assign mapped     = UW'(req_page) < r_used;

    assign size_pages = r_req.node_size[SIZE_W-1:PAGE_SHIFT];
    assign bad_size   = (r_req.node_size < MIN_BYTES) || (|r_req.node_size[PAGE_SHIFT-1:0]);
    assign avail      = CMPW'(REGION_PAGES) - CMPW'(r_used);
    assign no_space   = (r_carved >= SW'(RECORD_COUNT)) || (CMPW'(size_pages) > avail);
    assign carve_ok   = !r_mode && (r_req.action == ACT_CARVE) && !bad_size && !no_space;
    assign carve_addr = base_bytes + (ADDR_W'(r_used) << PAGE_SHIFT);

    assign fill_next  = r_fill_pg + 1'b1;
    assign fill_last  = (fill_next == r_fill_end);

    assign map_we     = (r_state == S_FILL);
    assign map_wdata  = r_carved + 1'b1;
    assign slot_m1    = map_slot - 1'b1;
    assign rec_raddr  = slot_m1[RW-1:0];

    always_comb begin
        new_marks   = rec_marks;
        mark_status = ST_OK;
        inc_reuse   = 1'b0;
        inc_release = 1'b0;
        inc_discard = 1'b0;
        unique case (r_req.action)
            ACT_ISSUE: begin
                if (rec_marks[MK_LIVE] || rec_marks[MK_DISCARDED]) begin
                    mark_status = ST_ISSUE_ERR;
                end else begin
                    inc_reuse          = rec_marks[MK_RELEASED];
                    new_marks[MK_LIVE] = 1'b1;
                end
            end
            ACT_RELEASE: begin
                if (!rec_marks[MK_LIVE] || rec_marks[MK_DISCARDED]) begin
                    mark_status = ST_RELEASE_ERR;
                end else begin
                    inc_release            = 1'b1;
                    new_marks[MK_LIVE]     = 1'b0;
                    new_marks[MK_RELEASED] = 1'b1;
                end
            end
            ACT_DISCARD: begin
                if (rec_marks[MK_LIVE] || rec_marks[MK_DISCARDED]) begin
                    mark_status = ST_DISCARD_ERR;
                end else begin
                    inc_discard             = 1'b1;
                    new_marks[MK_DISCARDED] = 1'b1;
                end
            end
            default: begin
                mark_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        rec_we     = 1'b0;
        rec_waddr  = r_rec;
        rec_wstart = rec_start;
        rec_wmarks = new_marks;
        if (r_state == S_CHECK && carve_ok) begin
            rec_we     = 1'b1;
            rec_waddr  = r_carved[RW-1:0];
            rec_wstart = r_used[PW-1:0];
            rec_wmarks = '0;
        end else if (r_state == S_REC && rec_start == r_page && mark_status == ST_OK) begin
            rec_we = 1'b1;
        end
    end

    pnc_page_map #(
        .PAGES (REGION_PAGES),
        .PW    (PW),
        .SW    (SW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_fill_pg[PW-1:0]),
        .i_wdata (map_wdata),
        .i_raddr (req_page),
        .o_rdata (map_slot)
    );

    pnc_node_table #(
        .RECS (RECORD_COUNT),
        .RW   (RW),
        .PW   (PW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (rec_we),
        .i_waddr  (rec_waddr),
        .i_wstart (rec_wstart),
        .i_wmarks (rec_wmarks),
        .i_raddr  (rec_raddr),
        .o_rstart (rec_start),
        .o_rmarks (rec_marks)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_mode      <= 1'b0;
            r_carved    <= '0;
            r_used      <= '0;
            r_reuse     <= '0;
            r_release   <= '0;
            r_discard   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_MODE: r_mode <= i_cfg_data[0];
                    default:  r_mode <= r_mode;
                endcase
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_addr <= carve_ok ? carve_addr : '0;
                    if (r_mode) begin
                        r_res_status <= ST_MODE;
                        r_state      <= S_EMIT;
                    end else if (r_req.action == ACT_CARVE) begin
                        if (bad_size) begin
                            r_res_status <= ST_BAD_SIZE;
                            r_state      <= S_EMIT;
                        end else if (no_space) begin
                            r_res_status <= ST_NO_SPACE;
                            r_state      <= S_EMIT;
                        end else begin
                            r_res_status <= ST_OK;
                            r_fill_pg    <= r_used;
                            r_fill_end   <= r_used + UW'(size_pages);
                            r_state      <= S_FILL;
                        end
                    end else if (bad_addr) begin
                        r_res_status <= ST_BAD_ADDR;
                        r_state      <= S_EMIT;
                    end else begin
                        r_page   <= req_page;
                        r_mapped <= mapped;
                        r_state  <= S_MAP;
                    end
                end
                S_MAP: begin
                    if (!r_mapped || map_slot == '0) begin
                        r_res_status <= ST_UNMAPPED;
                        r_state      <= S_EMIT;
                    end else begin
                        r_rec   <= rec_raddr;
                        r_state <= S_REC;
                    end
                end
                S_REC: begin
                    r_state <= S_EMIT;
                    if (rec_start != r_page) begin
                        r_res_status <= ST_NOT_START;
                    end else begin
                        r_res_status <= mark_status;
                        if (mark_status == ST_OK) begin
                            r_res_addr <= r_req.node_address;
                        end
                        if (inc_reuse) begin
                            r_reuse <= r_reuse + 1'b1;
                        end
                        if (inc_release) begin
                            r_release <= r_release + 1'b1;
                        end
                        if (inc_discard) begin
                            r_discard <= r_discard + 1'b1;
                        end
                    end
                end
                S_FILL: begin
                    r_fill_pg <= fill_next;
                    if (fill_last) begin
                        r_used   <= r_fill_end;
                        r_carved <= r_carved + 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.status         <= r_res_status;
                        r_out.result_address <= r_res_addr;
                        r_out.nodes_carved   <= CNT_OUT_W'(r_carved);
                        r_out.pages_in_use   <= USE_OUT_W'(r_used);
                        r_out.reuses_seen    <= r_reuse;
                        r_out.releases_seen  <= r_release;
                        r_out.discards_seen  <= r_discard;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
